// ===== src/stored_array_element_search_assert.svh =====
// Assertion macros for the stored array element search RTL.
// Depends on nothing; included by stored_array_element_search, which checks its own logic.
`ifndef STORED_ARRAY_ELEMENT_SEARCH_ASSERT_SVH
`define STORED_ARRAY_ELEMENT_SEARCH_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define SASE_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

// Consequence must hold in the cycle after the trigger.
`define SASE_ASSERT_NEXT(lbl, clk, rst, trig, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("next-cycle property violated");

// Consequence must hold in the same cycle as the trigger.
`define SASE_ASSERT_SAME(lbl, clk, rst, trig, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error("same-cycle property violated");

`endif

// ===== src/sase_pkg.sv =====
// Types and constants of the stored array element search block.
// No dependencies; used by sase_cell and stored_array_element_search.
package sase_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 6;
   localparam int MASK_W  = 32;

   localparam logic [POS_W-1:0] POS_NONE = '1;   // -1 in six bits

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_SEARCH = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } state_type;

   // Operation and partial result traveling down the cell row.
   typedef struct packed {
      logic               valid;
      func_type           func;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   index;
      logic               found;
      logic [POS_W-1:0]   first;
      logic [POS_W-1:0]   last;
      logic [POS_W-1:0]   count;
      logic [MASK_W-1:0]  mask;
      logic [VALUE_W-1:0] element;
      logic               read_ok;
   } token_type;

endpackage

// ===== src/sase_cell.sv =====
// One cell of the entry row: holds a single entry and updates the passing token.
// Depends on sase_pkg.
module sase_cell #(
   parameter int POS   = 0,
   parameter int CNT_W = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [CNT_W-1:0]    used_count,
   input  sase_pkg::token_type tok_in,
   output sase_pkg::token_type tok_out
);

   logic [sase_pkg::VALUE_W-1:0] entry_ff;
   sase_pkg::token_type          tok_ff;
   sase_pkg::token_type          tok_in_next;
   logic                         in_use;
   logic                         hit;

   assign in_use = CNT_W'(POS) < used_count;
   assign hit    = in_use && (entry_ff == tok_in.value);

   // Store the appended value when this cell is the next free slot.
   always_ff @(posedge clock) begin
      if (tok_in.valid && tok_in.func == sase_pkg::FUNC_APPEND
          && used_count == CNT_W'(POS)) begin
         entry_ff <= tok_in.value;
      end
   end

   always_comb begin
      tok_in_next = tok_in;
      if (tok_in.func == sase_pkg::FUNC_SEARCH && hit) begin
         if (!tok_in.found) begin
            tok_in_next.first = sase_pkg::POS_W'(POS);
         end
         tok_in_next.found = 1'b1;
         tok_in_next.last  = sase_pkg::POS_W'(POS);
         tok_in_next.count = tok_in.count + 1'b1;
         if (POS < sase_pkg::MASK_W) begin
            tok_in_next.mask[5'(POS)] = 1'b1;
         end
      end
      if (tok_in.func == sase_pkg::FUNC_READ && in_use
          && tok_in.index == sase_pkg::POS_W'(POS)) begin
         tok_in_next.element = entry_ff;
         tok_in_next.read_ok = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== src/stored_array_element_search.sv =====
// Top level of the stored array element search block: handshakes, control, cell row.
// Depends on sase_pkg, sase_cell and stored_array_element_search_assert.svh.
//
//   channel | dir | tdata                        | tuser
//   --------+-----+------------------------------+--------------
//   req_    | in  | value, index                 | func
//   rsp_    | out | found, first/last, count,    | status
//           |     | mask, element, used_size     |
//
// One item at a time: an accepted beat enters the launch register, then walks
// the row of DEPTH cells, one cell per cycle, and lands in the response register.
// A new beat is accepted only after the previous response has been taken, even with
// rsp_tready held high; most of that wait is the walk through the cell row.
// Reset clears the used count, the FSM and every token valid; entries are not cleared.
// A stalled response holds in its register and req_tready stays low until taken.
`include "stored_array_element_search_assert.svh"

module stored_array_element_search #(
   parameter int DEPTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // [31:0] value, [37:32] index, rest zero
   input  logic [1:0]   req_tuser,   // [1:0] func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // [0] found, [6:1] first_index, [12:7] last_index,
                                     // [18:13] match_count, [50:19] hit_mask,
                                     // [82:51] element, [88:83] used_size, rest zero
   output logic [1:0]   rsp_tuser    // [1:0] status
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   sase_pkg::state_type  state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   sase_pkg::token_type  launch_ff, launch_in;
   sase_pkg::token_type  chain [DEPTH+1];
   sase_pkg::token_type  tail;
   logic [DEPTH:0]       tok_valid;
   logic                 req_beat;
   logic                 rsp_beat;

   logic                       found_ff;
   logic [sase_pkg::POS_W-1:0] first_ff, last_ff, match_ff, used_ff;
   logic [31:0]                mask_ff;
   logic [31:0]                element_ff;
   sase_pkg::status_type       status_ff, status_in;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;
   assign tail     = chain[DEPTH];

   // Next state: launch on accept, park on the returning token, drop on take.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sase_pkg::ST_IDLE: if (req_beat)   state_in = sase_pkg::ST_RUN;
         sase_pkg::ST_RUN:  if (tail.valid) state_in = sase_pkg::ST_HOLD;
         sase_pkg::ST_HOLD: if (rsp_beat)   state_in = sase_pkg::ST_IDLE;
         default:                           state_in = sase_pkg::ST_IDLE;
      endcase
   end

   // Handshake outputs follow the state.
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         sase_pkg::ST_IDLE: req_tready = 1'b1;
         sase_pkg::ST_HOLD: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   // Build a fresh token with the "nothing found" defaults.
   always_comb begin
      launch_in         = '0;
      launch_in.valid   = req_beat;
      launch_in.func    = sase_pkg::func_type'(req_tuser);
      launch_in.value   = req_tdata[31:0];
      launch_in.index   = req_tdata[37:32];
      launch_in.first   = sase_pkg::POS_NONE;
      launch_in.last    = sase_pkg::POS_NONE;
   end

   // Update the used count and status once the token leaves the row.
   always_comb begin
      count_in  = count_ff;
      status_in = sase_pkg::STATUS_OK;
      case (tail.func)
         sase_pkg::FUNC_CLEAR: count_in = '0;
         sase_pkg::FUNC_APPEND: begin
            if (count_ff == CNT_W'(DEPTH)) begin
               status_in = sase_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         sase_pkg::FUNC_READ: begin
            if (!tail.read_ok) begin
               status_in = sase_pkg::STATUS_RANGE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sase_pkg::ST_IDLE;
         count_ff  <= '0;
         launch_ff <= '0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= launch_in;
         if (tail.valid) begin
            count_ff <= count_in;
         end
      end
   end

   // Capture the response; hold it while the sink stalls.
   always_ff @(posedge clock) begin
      if (tail.valid) begin
         status_ff  <= status_in;
         found_ff   <= tail.found;
         first_ff   <= tail.first;
         last_ff    <= tail.last;
         match_ff   <= tail.count;
         mask_ff    <= tail.mask;
         element_ff <= tail.element;
         used_ff    <= sase_pkg::POS_W'(count_in);
      end
   end

   assign chain[0] = launch_ff;

   // Row of cells; cell i holds entry i and passes the token on each cycle.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      sase_cell #(
         .POS   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .used_count (count_ff),
         .tok_in     (chain[i]),
         .tok_out    (chain[i+1])
      );
   end

   for (genvar i = 0; i <= DEPTH; i++) begin : g_valid
      assign tok_valid[i] = chain[i].valid;
   end

   assign rsp_tuser = status_ff;
   assign rsp_tdata = {7'd0, used_ff, element_ff, mask_ff, match_ff,
                       last_ff, first_ff, found_ff};

   // Only one operation may be in flight along the row.
   `SASE_ASSERT_ALWAYS(a_single_token, clock, reset, $countones(tok_valid) <= 1)
   // The used count never passes the capacity.
   `SASE_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   // A token reaches the end of the row only while the FSM waits for it.
   `SASE_ASSERT_SAME(a_tail_in_run, clock, reset, tail.valid, state_ff == sase_pkg::ST_RUN)
   // After an accept the block is busy and has launched the token.
   `SASE_ASSERT_NEXT(a_accept_busy, clock, reset, req_beat, !req_tready && launch_ff.valid)

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for stored_array_element_search: clear, append, search and read traffic.
// Depends on sase_pkg and the stored_array_element_search RTL.
// An in-bench array model predicts every response beat; a checker compares them field by field.
module tb_top;
   import sase_pkg::*;

   localparam int DEPTH        = 32;
   localparam int ITEM_TARGET  = 450;   // stop random traffic once this many beats went in
   localparam int HOLD_CYCLES  = 400;   // receiver hold-off during the backpressure test
   localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either side before giving up
   localparam int TAIL_CYCLES  = DEPTH + 8;

   // One predicted response beat, unpacked.
   typedef struct {
      status_type  status;
      logic        found;
      logic [5:0]  first_pos;
      logic [5:0]  last_pos;
      logic [5:0]  hits;
      logic [31:0] mask;
      logic [31:0] element;
      logic [5:0]  used;
   } search_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [39:0]  req_tdata;   // [31:0] value, [37:32] index, [39:38] zero
   logic [1:0]   req_tuser;   // [1:0] func
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;   // [0] found, [6:1] first, [12:7] last, [18:13] count,
                              // [50:19] mask, [82:51] element, [88:83] used_size, rest zero
   logic [1:0]   rsp_tuser;   // [1:0] status

   // Array model: contents and number of entries in use.
   logic [31:0]       model_entries [DEPTH];
   int unsigned       model_used;
   search_result_type expected_results [$];

   // Values that appends and searches draw from, so that searches hit.
   logic [31:0] value_pool [4];

   int unsigned items_sent;
   int unsigned results_checked;
   int unsigned search_hits;
   int unsigned dropped_appends;
   int unsigned range_reads;
   int unsigned error_count;
   int unsigned quiet_cycles;
   int unsigned burst_left;
   bit          hold_request;

   stored_array_element_search #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Array model
   // ---------------------------------------------------------------------------

   // Apply one accepted beat to the model and return the response it must produce.
   function automatic search_result_type predict_result(func_type f, logic [31:0] v,
                                                        logic [5:0] idx);
      search_result_type r;
      r.status    = STATUS_OK;
      r.found     = 1'b0;
      r.first_pos = POS_NONE;
      r.last_pos  = POS_NONE;
      r.hits      = '0;
      r.mask      = '0;
      r.element   = '0;
      case (f)
         FUNC_CLEAR: begin
            model_used = 0;   // entries stay, but become unreachable
         end
         FUNC_APPEND: begin
            if (model_used < DEPTH) begin
               model_entries[model_used] = v;
               model_used++;
            end else begin
               r.status = STATUS_FULL;
               dropped_appends++;
            end
         end
         FUNC_SEARCH: begin
            for (int i = 0; i < DEPTH; i++) begin
               if (i < model_used && model_entries[i] == v) begin
                  if (r.hits == 0) r.first_pos = 6'(i);
                  r.last_pos = 6'(i);
                  r.hits     = r.hits + 6'd1;
                  if (i < 32) r.mask[i] = 1'b1;
               end
            end
            r.found = (r.hits != 0);
            if (r.found) search_hits++;
         end
         default: begin
            if (idx < model_used) begin
               r.element = model_entries[idx];
            end else begin
               r.status = STATUS_RANGE;
               range_reads++;
            end
         end
      endcase
      r.used = 6'(model_used);
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------

   // Mostly back-to-back or short gaps, now and then a long one; bursts run with none.
   function automatic int unsigned next_gap();
      int unsigned roll;
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
         burst_left = $urandom_range(10, 30);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Offer one beat at a falling edge, hold it until accepted, then log its prediction.
   task automatic send_beat(func_type f, logic [31:0] v, logic [5:0] idx);
      int unsigned gap;
      gap = next_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, idx, v};
      req_tuser  <= f;
      do @(posedge clock); while (!req_tready);
      expected_results.insert(expected_results.size(), predict_result(f, v, idx));
      items_sent++;
   endtask

   function automatic logic [5:0] any_index();
      return 6'($urandom_range(0, 63));
   endfunction

   // Pick a readable position, or 0 on an empty array.
   function automatic logic [5:0] used_index();
      if (model_used == 0) return 6'd0;
      return 6'($urandom_range(0, model_used - 1));
   endfunction

   function automatic void refresh_pool();
      logic [31:0] extremes [4];
      extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
      foreach (value_pool[i])
         value_pool[i] = ($urandom_range(0, 4) == 0) ? extremes[$urandom_range(0, 3)]
                                                     : $urandom();
   endfunction

   function automatic logic [31:0] pool_value();
      return value_pool[$urandom_range(0, 3)];
   endfunction

   // ---------------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------------

   // Runs of ready and stall of random length; a hold request forces one long stall.
   initial begin : rsp_driver
      int unsigned run_left;
      int unsigned roll;
      rsp_tready = 1'b0;
      run_left   = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            run_left   = HOLD_CYCLES - 1;
         end else if (run_left != 0) begin
            run_left--;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
               rsp_tready <= 1'b1;
               run_left   = $urandom_range(40, 150);
            end else if (roll < 60) begin
               rsp_tready <= 1'b1;
               run_left   = $urandom_range(0, 8);
            end else if (roll < 93) begin
               rsp_tready <= 1'b0;
               run_left   = $urandom_range(0, 4);
            end else begin
               rsp_tready <= 1'b0;
               run_left   = $urandom_range(20, 80);
            end
         end
      end
   end

   task automatic report_mismatch(string msg);
      error_count++;
      $display("MISMATCH beat %0d: %s", results_checked, msg);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // Compare every accepted response beat with the oldest prediction.
   always @(posedge clock) begin : result_checker
      search_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("response beat with no request pending");
         end else begin
            want = expected_results.pop_front();
            check_field("status",      32'(rsp_tuser),        32'(want.status));
            check_field("found",       32'(rsp_tdata[0]),     32'(want.found));
            check_field("first_index", 32'(rsp_tdata[6:1]),   32'(want.first_pos));
            check_field("last_index",  32'(rsp_tdata[12:7]),  32'(want.last_pos));
            check_field("match_count", 32'(rsp_tdata[18:13]), 32'(want.hits));
            check_field("hit_mask",    rsp_tdata[50:19],      want.mask);
            check_field("element",     rsp_tdata[82:51],      want.element);
            check_field("used_size",   32'(rsp_tdata[88:83]), 32'(want.used));
            check_field("padding",     32'(rsp_tdata[95:89]), 32'd0);
         end
         results_checked++;
      end
   end

   // Give up when neither side moves a beat for too long.
   always @(posedge clock) begin : stall_watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("stored_array_element_search verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Empty array, extreme values, duplicates, misses, range edges and stale entries.
   task automatic test_directed();
      send_beat(FUNC_CLEAR,  32'h0000_0000, 6'd0);
      send_beat(FUNC_SEARCH, 32'h0000_0000, 6'd63);        // empty: nothing found
      send_beat(FUNC_READ,   32'hFFFF_FFFF, 6'd0);         // empty: out of range
      send_beat(FUNC_APPEND, 32'h8000_0000, 6'd0);
      send_beat(FUNC_APPEND, 32'h7FFF_FFFF, 6'd63);
      send_beat(FUNC_APPEND, 32'h0000_0000, 6'd21);
      send_beat(FUNC_APPEND, 32'hFFFF_FFFF, 6'd42);
      send_beat(FUNC_APPEND, 32'h8000_0000, 6'd0);
      send_beat(FUNC_SEARCH, 32'h8000_0000, 6'd0);         // two hits, first 0 last 4
      send_beat(FUNC_SEARCH, 32'h7FFF_FFFF, 6'd0);
      send_beat(FUNC_SEARCH, 32'hFFFF_FFFF, 6'd0);
      send_beat(FUNC_SEARCH, 32'h0000_0000, 6'd0);
      send_beat(FUNC_SEARCH, 32'h0000_0001, 6'd0);         // miss
      send_beat(FUNC_READ,   32'h0000_0000, 6'd0);
      send_beat(FUNC_READ,   32'h0000_0000, 6'd4);         // last used entry
      send_beat(FUNC_READ,   32'h0000_0000, 6'd5);         // first unused position
      send_beat(FUNC_READ,   32'h0000_0000, 6'd63);
      send_beat(FUNC_CLEAR,  32'hFFFF_FFFF, 6'd63);
      send_beat(FUNC_SEARCH, 32'h8000_0000, 6'd0);         // stale entries unreachable
      send_beat(FUNC_READ,   32'h0000_0000, 6'd0);
      send_beat(FUNC_APPEND, 32'h5555_5555, 6'd0);
      send_beat(FUNC_READ,   32'h0000_0000, 6'd0);
      send_beat(FUNC_SEARCH, 32'hAAAA_AAAA, 6'd0);
   endtask

   // Fill to capacity twice: once with a single value, once from a small pool.
   task automatic test_capacity();
      logic [31:0] fill;
      fill = $urandom();
      send_beat(FUNC_CLEAR, $urandom(), any_index());
      repeat (DEPTH) send_beat(FUNC_APPEND, fill, any_index());
      send_beat(FUNC_SEARCH, fill, any_index());           // every position matches
      send_beat(FUNC_SEARCH, ~fill, any_index());
      send_beat(FUNC_APPEND, $urandom(), any_index());     // full: dropped
      send_beat(FUNC_APPEND, fill, any_index());
      send_beat(FUNC_READ, $urandom(), 6'(DEPTH - 1));
      send_beat(FUNC_READ, $urandom(), 6'(DEPTH));
      refresh_pool();
      send_beat(FUNC_CLEAR, $urandom(), any_index());
      repeat (DEPTH) send_beat(FUNC_APPEND, pool_value(), any_index());
      foreach (value_pool[i]) send_beat(FUNC_SEARCH, value_pool[i], any_index());
      send_beat(FUNC_APPEND, pool_value(), any_index());
      repeat (4) send_beat(FUNC_READ, $urandom(), used_index());
   endtask

   // Stall the receiver for a long stretch while the sender keeps offering beats.
   task automatic test_backpressure();
      hold_request = 1'b1;
      burst_left   = 12;
      send_beat(FUNC_CLEAR, $urandom(), any_index());
      repeat (4) send_beat(FUNC_APPEND, pool_value(), any_index());
      repeat (4) send_beat(FUNC_SEARCH, pool_value(), any_index());
      repeat (3) send_beat(FUNC_READ, $urandom(), any_index());
   endtask

   // Well-formed fill-and-query sequences with random content, plus some noise.
   task automatic test_random_traffic();
      int unsigned kind;
      int unsigned n_append;
      int unsigned n_query;
      while (items_sent < ITEM_TARGET) begin
         kind = $urandom_range(0, 99);
         if (kind < 12) begin
            repeat (8) send_beat(func_type'($urandom_range(0, 3)), $urandom(), any_index());
         end else begin
            refresh_pool();
            // Skip the clear now and then so the array keeps growing toward full.
            if (kind < 85) send_beat(FUNC_CLEAR, $urandom(), any_index());
            n_append = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40)
                                                   : $urandom_range(0, 12);
            repeat (n_append)
               send_beat(FUNC_APPEND, ($urandom_range(0, 3) == 0) ? $urandom() : pool_value(),
                         any_index());
            n_query = $urandom_range(2, 8);
            repeat (n_query) begin
               if ($urandom_range(0, 9) < 6)
                  send_beat(FUNC_SEARCH,
                            ($urandom_range(0, 3) == 0) ? $urandom() : pool_value(),
                            any_index());
               else
                  send_beat(FUNC_READ, $urandom(),
                            ($urandom_range(0, 3) == 0) ? any_index() : used_index());
            end
         end
      end
   endtask

   initial begin : run_tests
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = FUNC_CLEAR;
      model_used      = 0;
      items_sent      = 0;
      results_checked = 0;
      search_hits     = 0;
      dropped_appends = 0;
      range_reads     = 0;
      error_count     = 0;
      quiet_cycles    = 0;
      burst_left      = 0;
      hold_request    = 1'b0;
      refresh_pool();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_capacity();
      test_backpressure();
      test_random_traffic();

      // Stop offering, drain, then watch a while for stray beats.
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d requests, checked %0d responses, with a %0d-cycle receiver hold.",
               items_sent, results_checked, HOLD_CYCLES);
      $display("Saw %0d searches with hits, %0d dropped appends, %0d out-of-range reads.",
               search_hits, dropped_appends, range_reads);
      if (error_count == 0)
         $display("stored_array_element_search verification clean");
      else
         $display("stored_array_element_search verification failed");
      $finish;
   end

endmodule

// ===== stored_array_element_search.f =====
+incdir+src
src/sase_pkg.sv
src/sase_cell.sv
src/stored_array_element_search.sv
verif/tb_top.sv
